// ----- rtl/core/apfdb_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse finder package
// Shared widths, register indexes, sequencer states and cell control type.
// ----------------------------------------------------------------------------
package apfdb_pkg;

  localparam int WINDOW_DEF      = 10;
  localparam int MAX_SAMPLES_DEF = 65536;

  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 17;
  localparam int THR_W     = 16;
  localparam int MINW_W    = 10;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // A window sample counts as quiet when it lies strictly closer than this.
  localparam logic [SAMPLE_W-1:0] NEAR_LIMIT = SAMPLE_W'(5);

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVIDE,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/apfdb_in_if.sv -----
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one ADC sample and its waveform marker.
// ----------------------------------------------------------------------------
interface apfdb_in_if
  import apfdb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                first_of_wave;

  modport source (output valid, output sample, output first_of_wave, input ready);
  modport sink   (input valid, input sample, input first_of_wave, output ready);
endinterface

// ----- rtl/core/apfdb_out_if.sv -----
// ----------------------------------------------------------------------------
// Pulse channel
// Valid/ready channel that carries one pulse result.
// ----------------------------------------------------------------------------
interface apfdb_out_if
  import apfdb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   start_time;
  logic [SAMPLE_W-1:0] peak_index;
  logic [SAMPLE_W-1:0] baseline_value;
  logic [TIME_W-1:0]   end_time;
  logic [SAMPLE_W-1:0] pulse_number;

  modport source (output valid, output start_time, output peak_index,
                  output baseline_value, output end_time, output pulse_number,
                  input ready);
  modport sink   (input valid, input start_time, input peak_index,
                  input baseline_value, input end_time, input pulse_number,
                  output ready);
endinterface

// ----- rtl/core/adc_pulse_finder_dynamic_baseline.sv -----
// ----------------------------------------------------------------------------
// ADC pulse finder with dynamic baseline
// Finds pulses above a moving baseline in a stream of ADC waveform samples.
// ----------------------------------------------------------------------------
// One sample is taken per request and processed before the next one is
// taken. A sample whose window is not quiet goes through the window scan
// and the decision; a quiet window adds the mean division between them. The
// time a sample takes is set by the rotation of the window cell chain past
// its tap, one cell per cycle, and by the one-bit-per-cycle divider over
// SUM_W bits, 16 plus the bits of the window index. A finished pulse sits in
// an output register, so new samples are taken while it waits; a second
// pulse that closes before the first is taken holds the block until the
// output register frees.
module adc_pulse_finder_dynamic_baseline
  import apfdb_pkg::*;
#(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  apfdb_in_if.sink             in_i,
  apfdb_out_if.source          out_o
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SCAN_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_W + SCAN_W;
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam logic [CNT_W-1:0]  FILL_MAX  = CNT_W'(WINDOW);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(WINDOW - 1);
  localparam logic [IDX_W-1:0]  IDX_MAX   = IDX_W'(MAX_SAMPLES - 1);

  state_e state_q, state_d;

  logic [THR_W-1:0]    thr_q;
  logic [MINW_W-1:0]   minw_q;
  logic [CNT_W-1:0]    fill_q;
  logic [SAMPLE_W-1:0] base_q;
  logic [IDX_W-1:0]    idx_q;
  logic                pulse_q;
  logic [SAMPLE_W-1:0] run_q;
  logic [SAMPLE_W-1:0] peak_exc_q;
  logic [IDX_W-1:0]    peak_pos_q;
  logic [IDX_W-1:0]    start_q;
  logic [SAMPLE_W-1:0] count_q;
  logic [SAMPLE_W-1:0] cur_q;
  logic [SCAN_W-1:0]   scan_q;
  logic [SUM_W-1:0]    sum_q;
  logic                near_q;

  logic                out_valid_q;
  logic [TIME_W-1:0]   out_start_q;
  logic [SAMPLE_W-1:0] out_peak_q;
  logic [SAMPLE_W-1:0] out_base_q;
  logic [TIME_W-1:0]   out_end_q;
  logic [SAMPLE_W-1:0] out_num_q;

  logic                in_acc;
  logic                new_wave;
  cell_ctrl_t          cell_ctrl;
  logic [SAMPLE_W-1:0] cell_data [WINDOW];
  logic [SAMPLE_W-1:0] tap;
  logic                tap_used;
  logic                tap_near;
  logic [SAMPLE_W-1:0] tap_diff;
  logic [SUM_W-1:0]    sum_nx;
  logic                near_nx;
  logic                scan_done;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic [SAMPLE_W:0]   thr_level;
  logic                above;
  logic [SAMPLE_W-1:0] excess;
  logic                run_ok;
  logic                emit;
  logic                out_free;
  logic                out_load;
  logic [SAMPLE_W-1:0] count_nx;

  // Window cell chain: loads shift toward the tail, rotation runs toward cell 0.
  for (genvar c = 0; c < WINDOW; c++) begin : g_cell
    apfdb_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .shift_in_i ((c == 0) ? in_i.sample : cell_data[(c + WINDOW - 1) % WINDOW]),
      .rot_in_i   (cell_data[(c + 1) % WINDOW]),
      .data_o     (cell_data[c])
    );
  end

  assign tap      = cell_data[0];
  assign tap_used = CNT_W'(scan_q) < fill_q;
  assign tap_diff = (tap >= base_q) ? (tap - base_q) : (base_q - tap);
  assign tap_near = tap_diff < NEAR_LIMIT;
  assign sum_nx   = tap_used ? (sum_q + SUM_W'(tap)) : sum_q;
  assign near_nx  = near_q && (!tap_used || tap_near);
  assign scan_done = scan_q == SCAN_LAST;

  apfdb_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_nx),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign new_wave  = in_i.first_of_wave || (fill_q == '0);
  assign thr_level = {1'b0, base_q} + {1'b0, thr_q};
  assign above     = {1'b0, cur_q} > thr_level;
  assign excess    = cur_q - base_q;
  assign run_ok    = run_q >= SAMPLE_W'(minw_q);
  assign emit      = !above && pulse_q && run_ok;
  assign out_free  = !out_valid_q || out_o.ready;
  assign count_nx  = (count_q != '1) ? (count_q + SAMPLE_W'(1)) : count_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = near_nx ? ST_DIVIDE : ST_DECIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!emit || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready       = 1'b0;
    cell_ctrl.load   = 1'b0;
    cell_ctrl.rotate = 1'b0;
    div_start        = 1'b0;
    out_load         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready     = 1'b1;
        cell_ctrl.load = in_i.valid;
      end
      ST_SCAN: begin
        cell_ctrl.rotate = 1'b1;
        div_start        = scan_done && near_nx;
      end
      ST_DIVIDE: begin
      end
      ST_DECIDE: begin
        out_load = emit && out_free;
      end
      default: begin
      end
    endcase
  end

  assign in_acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= '0;
      minw_q      <= '0;
      fill_q      <= '0;
      base_q      <= '0;
      idx_q       <= '0;
      pulse_q     <= 1'b0;
      run_q       <= '0;
      peak_exc_q  <= '0;
      peak_pos_q  <= '0;
      start_q     <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      near_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_THRESHOLD: thr_q  <= cfg_wdata_i[THR_W-1:0];
          REG_MIN_WIDTH: minw_q <= cfg_wdata_i[MINW_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_acc) begin
        scan_q <= '0;
        near_q <= 1'b1;
        if (new_wave) begin
          fill_q     <= CNT_W'(1);
          base_q     <= in_i.sample;
          idx_q      <= '0;
          pulse_q    <= 1'b0;
          run_q      <= '0;
          peak_exc_q <= '0;
          peak_pos_q <= '0;
          start_q    <= '0;
          count_q    <= '0;
        end else begin
          if (idx_q != IDX_MAX) begin
            idx_q <= idx_q + IDX_W'(1);
          end
          if (fill_q != FILL_MAX) begin
            fill_q <= fill_q + CNT_W'(1);
          end
        end
      end

      if (state_q == ST_SCAN) begin
        scan_q <= scan_q + SCAN_W'(1);
        near_q <= near_nx;
      end

      if ((state_q == ST_DIVIDE) && div_done) begin
        base_q <= div_quo[SAMPLE_W-1:0];
      end

      if (state_q == ST_DECIDE) begin
        if (above) begin
          if (!pulse_q) begin
            start_q <= idx_q;
          end
          pulse_q <= 1'b1;
          if (run_q != '1) begin
            run_q <= run_q + SAMPLE_W'(1);
          end
          if (excess > peak_exc_q) begin
            peak_exc_q <= excess;
            peak_pos_q <= idx_q;
          end
        end else if (!emit || out_free) begin
          pulse_q    <= 1'b0;
          run_q      <= '0;
          peak_exc_q <= '0;
          if (emit) begin
            count_q <= count_nx;
          end
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q <= in_i.sample;
    end
    if (in_acc) begin
      sum_q <= '0;
    end else if (state_q == ST_SCAN) begin
      sum_q <= sum_nx;
    end
    if (out_load) begin
      out_start_q <= {SAMPLE_W'(start_q), 1'b0};
      out_peak_q  <= SAMPLE_W'(peak_pos_q);
      out_base_q  <= base_q;
      out_end_q   <= {SAMPLE_W'(idx_q), 1'b0};
      out_num_q   <= count_nx;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.start_time     = out_start_q;
  assign out_o.peak_index     = out_peak_q;
  assign out_o.baseline_value = out_base_q;
  assign out_o.end_time       = out_end_q;
  assign out_o.pulse_number   = out_num_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("Window fill count exceeds the window depth.");

  a_accept_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SCAN) && (scan_q == '0))
    else $error("An accepted sample did not start a window scan.");

  a_emit_open_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> pulse_q && (run_q != '0))
    else $error("A pulse was emitted without an open run.");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_q |-> (run_q != '0))
    else $error("An open run has zero length.");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVIDE))
    else $error("The divider finished outside the divide state.");

endmodule

// ----- rtl/core/apfdb_cell.sv -----
// ----------------------------------------------------------------------------
// Window cell
// Holds one window sample; shifts in a new sample or rotates with its neighbor.
// ----------------------------------------------------------------------------
module apfdb_cell
  import apfdb_pkg::*;
(
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic [SAMPLE_W-1:0] shift_in_i,
  input  logic [SAMPLE_W-1:0] rot_in_i,
  output logic [SAMPLE_W-1:0] data_o
);

  logic [SAMPLE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.load) begin
      data_q <= shift_in_i;
    end else if (ctrl_i.rotate) begin
      data_q <= rot_in_i;
    end else begin
      data_q <= data_q;
    end
  end

  assign data_o = data_q;

endmodule

// ----- rtl/core/apfdb_div.sv -----
// ----------------------------------------------------------------------------
// Window mean divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apfdb_div
  import apfdb_pkg::*;
#(
  parameter int SUM_W = 20,
  parameter int CNT_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    trial_sub;

  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == LAST_STEP);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- tb/apfdb_pulse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse finder checker
// Watches the register port and both channels, predicts the pulse results of
// every accepted sample request and compares them with what the block sends.
// ----------------------------------------------------------------------------
module apfdb_pulse_checker
  import apfdb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  apfdb_in_if                  samples_i,
  apfdb_out_if                 pulses_i,
  output int unsigned          mismatches_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [TIME_W-1:0]   start_time;
    logic [SAMPLE_W-1:0] peak_index;
    logic [SAMPLE_W-1:0] baseline_value;
    logic [TIME_W-1:0]   end_time;
    logic [SAMPLE_W-1:0] pulse_number;
  } pulse_t;

  logic [SAMPLE_W-1:0] window_q [WINDOW_DEF];
  int unsigned         fill_q;
  int unsigned         base_q;
  int unsigned         index_q;
  int unsigned         run_len_q;
  int unsigned         peak_exc_q;
  int unsigned         peak_pos_q;
  int unsigned         start_pos_q;
  int unsigned         pulse_cnt_q;
  bit                  open_run_q;
  int unsigned         thr_q;
  int unsigned         min_width_q;
  pulse_t              expected_pulses [$];

  function automatic void restart_wave();
    int k;
    for (k = 0; k < WINDOW_DEF; k++) begin
      window_q[k] = '0;
    end
    fill_q      = 0;
    base_q      = 0;
    index_q     = 0;
    run_len_q   = 0;
    peak_exc_q  = 0;
    peak_pos_q  = 0;
    start_pos_q = 0;
    pulse_cnt_q = 0;
    open_run_q  = 1'b0;
  endfunction

  function automatic bit track_sample(input logic [SAMPLE_W-1:0] value, input logic first,
                                      output pulse_t pulse);
    int unsigned sum;
    bit          quiet;
    bit          found;
    int          diff;
    int          excess;
    int          k;
    pulse = '0;
    found = 1'b0;
    if (first || fill_q == 0) begin
      restart_wave();
      base_q = value;
    end else if (index_q < MAX_SAMPLES_DEF - 1) begin
      index_q++;
    end
    for (k = WINDOW_DEF - 1; k > 0; k--) begin
      window_q[k] = window_q[k-1];
    end
    window_q[0] = value;
    if (fill_q < WINDOW_DEF) begin
      fill_q++;
    end
    quiet = 1'b1;
    sum   = 0;
    for (k = 0; k < fill_q; k++) begin
      diff = int'(window_q[k]) - int'(base_q);
      if (diff <= -int'(NEAR_LIMIT) || diff >= int'(NEAR_LIMIT)) begin
        quiet = 1'b0;
      end
      sum += window_q[k];
    end
    if (quiet) begin
      base_q = sum / fill_q;
    end
    excess = int'(value) - int'(base_q);
    if (excess > int'(thr_q)) begin
      if (!open_run_q) begin
        start_pos_q = index_q;
      end
      open_run_q = 1'b1;
      if (run_len_q < 'hFFFF) begin
        run_len_q++;
      end
      if (excess > int'(peak_exc_q)) begin
        peak_exc_q = excess;
        peak_pos_q = index_q;
      end
    end else begin
      if (open_run_q && run_len_q >= min_width_q) begin
        if (pulse_cnt_q < 'hFFFF) begin
          pulse_cnt_q++;
        end
        pulse.start_time     = TIME_W'(2 * start_pos_q);
        pulse.peak_index     = SAMPLE_W'(peak_pos_q);
        pulse.baseline_value = SAMPLE_W'(base_q);
        pulse.end_time       = TIME_W'(2 * index_q);
        pulse.pulse_number   = SAMPLE_W'(pulse_cnt_q);
        found = 1'b1;
      end
      open_run_q = 1'b0;
      run_len_q  = 0;
      peak_exc_q = 0;
    end
    return found;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pulse_t got;
    pulse_t want;
    if (!rst_ni) begin
      thr_q       = 0;
      min_width_q = 0;
      restart_wave();
      expected_pulses.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (pulses_i.valid && pulses_i.ready) begin
        got.start_time     = pulses_i.start_time;
        got.peak_index     = pulses_i.peak_index;
        got.baseline_value = pulses_i.baseline_value;
        got.end_time       = pulses_i.end_time;
        got.pulse_number   = pulses_i.pulse_number;
        if (expected_pulses.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) begin
            $display("Unexpected pulse: start %0d peak %0d baseline %0d end %0d number %0d",
                     got.start_time, got.peak_index, got.baseline_value, got.end_time,
                     got.pulse_number);
          end
        end else begin
          want = expected_pulses.pop_front();
          if (got.start_time !== want.start_time || got.peak_index !== want.peak_index ||
              got.baseline_value !== want.baseline_value ||
              got.end_time !== want.end_time || got.pulse_number !== want.pulse_number) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("Pulse mismatch: expected start %0d peak %0d baseline %0d end %0d %s",
                       want.start_time, want.peak_index, want.baseline_value,
                       want.end_time, $sformatf("number %0d", want.pulse_number));
              $display("                actual   start %0d peak %0d baseline %0d end %0d %s",
                       got.start_time, got.peak_index, got.baseline_value,
                       got.end_time, $sformatf("number %0d", got.pulse_number));
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD: thr_q = cfg_wdata_i[THR_W-1:0];
          REG_MIN_WIDTH: min_width_q = cfg_wdata_i[MINW_W-1:0];
          default: ;
        endcase
      end
      if (samples_i.valid && samples_i.ready) begin
        if (track_sample(samples_i.sample, samples_i.first_of_wave, want)) begin
          expected_pulses.insert(expected_pulses.size(), want);
        end
      end
      pending_o = expected_pulses.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse finder testbench
// Drives directed and random waveforms with random stalls on both channels
// under several threshold and width settings; a checker predicts each pulse.
// ----------------------------------------------------------------------------
module tb
  import apfdb_pkg::*;
();

  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int unsigned          mismatch_cnt;
  int unsigned          pending_cnt;
  int unsigned          sent_cnt;
  int unsigned          cycle_cnt;
  int unsigned          send_gap_pct;
  int unsigned          take_gap_pct;

  apfdb_in_if  in_ch ();
  apfdb_out_if out_ch ();

  adc_pulse_finder_dynamic_baseline i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  apfdb_pulse_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .samples_i    (in_ch),
    .pulses_i     (out_ch),
    .mismatches_o (mismatch_cnt),
    .pending_o    (pending_cnt)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input int value);
    if (value < 0) begin
      return '0;
    end else if (value > 65535) begin
      return '1;
    end
    return SAMPLE_W'(value);
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return int'($urandom_range(0, 40));
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic first);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sample        <= value;
    in_ch.first_of_wave <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_cnt++;
  endtask

  // The last sample may still be in flight even though no pulse is awaited.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_settings(input int unsigned thr, input int unsigned min_width);
    logic [CFG_W-1:0] word;
    word = CFG_W'($urandom);
    word[MINW_W-1:0] = MINW_W'(min_width);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_THRESHOLD;
    cfg_wdata <= CFG_W'(thr);
    @(negedge clk);
    cfg_idx   <= REG_MIN_WIDTH;
    cfg_wdata <= word;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_wave(input int thr, input int len_hint);
    int base;
    int len;
    int lift;
    int style;
    base = pick_level();
    send_sample(clamp_sample(base), $urandom_range(0, 7) != 0);
    repeat ($urandom_range(2, 10)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 12))
            send_sample(clamp_sample(base + int'($urandom_range(0, 8)) - 4), 1'b0);
        end
        4, 5, 6, 7: begin
          case ($urandom_range(0, 3))
            0: len = len_hint;
            1: len = len_hint - 1;
            2: len = len_hint + 1;
            default: len = $urandom_range(1, 8);
          endcase
          style = $urandom_range(0, 2);
          lift  = $urandom_range(1, 3);
          repeat (len) begin
            if (style == 0) begin
              send_sample(clamp_sample(base + thr + int'($urandom_range(0, 8)) - 3), 1'b0);
            end else if (style == 1) begin
              send_sample(clamp_sample(base + thr + 4 + lift + int'($urandom_range(0, 1))),
                          1'b0);
            end else begin
              send_sample(clamp_sample(base + thr + int'($urandom_range(5, 4000))), 1'b0);
            end
          end
        end
        8: begin
          repeat ($urandom_range(1, 3))
            send_sample(SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
        end
        default: begin
          base = pick_level();
          send_sample(clamp_sample(base), 1'b1);
        end
      endcase
    end
  endtask

  task automatic run_phase(input int unsigned thr, input int unsigned min_width,
                           input int len_hint, input int unsigned gap_pct,
                           input int unsigned goal);
    settle_block();
    write_settings(thr, min_width);
    send_gap_pct = gap_pct;
    take_gap_pct = gap_pct;
    goal += sent_cnt;
    while (sent_cnt < goal) random_wave(int'(thr), len_hint);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (take_gap_pct != 0 && $urandom_range(0, 99) < take_gap_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned thr_cfg;
    int unsigned mw_cfg;
    int          base;
    int          k;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_THRESHOLD;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.sample        = '0;
    in_ch.first_of_wave = 1'b0;
    sent_cnt            = 0;
    send_gap_pct        = 0;
    take_gap_pct        = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With reset settings the first sample opens a waveform on its own.
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1002, 1'b0);
    send_sample(16'd998, 1'b0);
    send_sample(16'd5000, 1'b0);
    send_sample(16'd7000, 1'b0);
    send_sample(16'd7000, 1'b0);
    send_sample(16'd6000, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd9000, 1'b0);
    send_sample(16'd300, 1'b1);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd0, 1'b1);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd65535, 1'b1);
    send_sample(16'd0, 1'b0);
    settle_block();
    write_settings(50, 3);
    send_sample(16'd2000, 1'b1);
    send_sample(16'd2200, 1'b0);
    send_sample(16'd2200, 1'b0);
    send_sample(16'd2001, 1'b0);
    send_sample(16'd2200, 1'b0);
    send_sample(16'd2300, 1'b0);
    send_sample(16'd2250, 1'b0);
    send_sample(16'd2000, 1'b0);

    run_phase(0, 0, 1, 30, 200);
    mw_cfg = $urandom_range(1, 4);
    run_phase($urandom_range(1, 60), mw_cfg, mw_cfg, 0, 200);
    run_phase(65535, 1023, 3, 20, 60);
    mw_cfg = $urandom_range(0, 6);
    run_phase($urandom_range(100, 2000), mw_cfg, mw_cfg, 40, 250);

    // Runs just below, at and just above the minimum width.
    settle_block();
    thr_cfg = $urandom_range(1, 20);
    mw_cfg  = $urandom_range(8, 16);
    write_settings(thr_cfg, mw_cfg);
    send_gap_pct = 10;
    take_gap_pct = 10;
    base = $urandom_range(100, 60000);
    send_sample(clamp_sample(base), 1'b1);
    repeat (12) send_sample(clamp_sample(base + int'($urandom_range(0, 8)) - 4), 1'b0);
    for (k = 0; k < 3; k++) begin
      repeat (int'(mw_cfg) - 1 + k)
        send_sample(clamp_sample(base + int'(thr_cfg) + int'($urandom_range(10, 500))),
                    1'b0);
      repeat (3) send_sample(clamp_sample(base + int'($urandom_range(0, 8)) - 4), 1'b0);
    end

    mw_cfg = $urandom_range(0, 3);
    run_phase($urandom_range(0, 300), mw_cfg, mw_cfg, 25, 250);

    // The closing part runs without idling on either side.
    mw_cfg = $urandom_range(0, 3);
    run_phase($urandom_range(0, 300), mw_cfg, mw_cfg, 0, 100);

    settle_block();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
